### design/websocket_frame_unmasker_defines.svh
// assertion macros used by websocket_frame_unmasker.sv
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("websocket_frame_unmasker: same-cycle check failed");

// next-cycle implication, checked out of reset
`define WSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("websocket_frame_unmasker: next-cycle check failed");

`endif

### design/wsu_pkg.sv
package wsu_pkg;

  localparam int COUNTER_WIDTH_DEFAULT = 32;
  localparam int TOTAL_WIDTH           = 32;
  localparam int APB_ADDR_WIDTH        = 3;
  localparam int APB_DATA_WIDTH        = 32;

  localparam logic [6:0] LEN_FIELD_MASK = 7'h7F;
  localparam logic [6:0] LEN_EXT16      = 7'd126;
  localparam logic [6:0] LEN_EXT64      = 7'd127;
  localparam logic [7:0] DELIM_RESET    = 8'h0A;

  localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
  localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
  localparam logic [2:0] MASK_LAST_IDX  = 3'd3;

  // register index taken from paddr word address
  localparam logic REG_RECORD_DELIMITER = 1'b0;

  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT16   = 7'b0000100,
    PH_EXT64   = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_HALT    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0]             payload_byte;
    logic                   frame_end;
    logic                   decode_error;
    logic [TOTAL_WIDTH-1:0] bytes_total;
    logic [TOTAL_WIDTH-1:0] records_total;
  } result_t;

endpackage

### design/websocket_frame_unmasker.sv
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, data_byte            | sink
// out     | out_valid, out_ready, payload_byte,      | source
//         | frame_end, decode_error, bytes_total,    |
//         | records_total                            |
// apb     | psel, penable, pwrite, paddr, pwdata,    | slave
//         | prdata, pready                           |
// one byte per cycle while in_ready is high; payload bytes go to the out register
// no out beat for header, length or key beats, bar a zero-length frame's error beat
// an out register plus a one-entry skid keep in_ready high through one stalled out beat
// rst is synchronous; after a zero-length frame all later beats are dropped until rst
module websocket_frame_unmasker #(
  parameter int COUNTER_WIDTH = wsu_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         payload_byte,
  output logic                               frame_end,
  output logic                               decode_error,
  output logic [wsu_pkg::TOTAL_WIDTH-1:0]    bytes_total,
  output logic [wsu_pkg::TOTAL_WIDTH-1:0]    records_total,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsu_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [wsu_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [wsu_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import wsu_pkg::*;
  `include "websocket_frame_unmasker_defines.svh"

  logic [7:0]               record_delimiter;
  phase_t                   frame_phase, frame_phase_next;
  logic [2:0]               header_byte_index, header_byte_index_next;
  logic [63:0]              payload_remaining, payload_remaining_next;
  logic [31:0]              mask_word, mask_word_next;
  logic [1:0]               mask_position, mask_position_next;
  logic [COUNTER_WIDTH-1:0] payload_count, payload_count_next;
  logic [COUNTER_WIDTH-1:0] delim_count, delim_count_next;

  logic    in_fire;
  logic    res_emit;
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic [7:0] key_byte;
  logic [7:0] plain;
  logic [6:0] len7;

  // apb
  assign pready = 1'b1;
  assign prdata = APB_DATA_WIDTH'(record_delimiter);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_delimiter <= DELIM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[APB_ADDR_WIDTH-1] == REG_RECORD_DELIMITER) begin
      record_delimiter <= pwdata[7:0];
    end
  end

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (mask_position)
      2'd0:    key_byte = mask_word[31:24];
      2'd1:    key_byte = mask_word[23:16];
      2'd2:    key_byte = mask_word[15:8];
      default: key_byte = mask_word[7:0];
    endcase
  end

  assign plain = data_byte ^ key_byte;
  assign len7  = data_byte[6:0] & LEN_FIELD_MASK;

  // per-beat state update
  always_comb begin
    frame_phase_next       = frame_phase;
    header_byte_index_next = header_byte_index;
    payload_remaining_next = payload_remaining;
    mask_word_next         = mask_word;
    mask_position_next     = mask_position;
    payload_count_next     = payload_count;
    delim_count_next       = delim_count;
    res_emit               = 1'b0;
    res                    = '0;
    case (frame_phase)
      PH_HDR0: begin
        frame_phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        header_byte_index_next = '0;
        payload_remaining_next = '0;
        if (len7 == LEN_EXT16) begin
          frame_phase_next = PH_EXT16;
        end else if (len7 == LEN_EXT64) begin
          frame_phase_next = PH_EXT64;
        end else begin
          payload_remaining_next = 64'(len7);
          frame_phase_next       = PH_MASK;
        end
      end
      PH_EXT16, PH_EXT64: begin
        payload_remaining_next = {payload_remaining[55:0], data_byte};
        header_byte_index_next = header_byte_index + 3'd1;
        if ((frame_phase == PH_EXT16 && header_byte_index == EXT16_LAST_IDX) ||
            (frame_phase == PH_EXT64 && header_byte_index == EXT64_LAST_IDX)) begin
          header_byte_index_next = '0;
          frame_phase_next       = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_word_next         = {mask_word[23:0], data_byte};
        header_byte_index_next = header_byte_index + 3'd1;
        if (header_byte_index == MASK_LAST_IDX) begin
          header_byte_index_next = '0;
          mask_position_next     = '0;
          if (payload_remaining == '0) begin
            frame_phase_next   = PH_HALT;
            res_emit           = 1'b1;
            res.decode_error   = 1'b1;
            res.bytes_total    = TOTAL_WIDTH'(payload_count);
            res.records_total  = TOTAL_WIDTH'(delim_count);
          end else begin
            frame_phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_position_next     = mask_position + 2'd1;
        payload_remaining_next = payload_remaining - 64'd1;
        if (payload_count != '1) begin
          payload_count_next = payload_count + COUNTER_WIDTH'(1);
        end
        if (plain == record_delimiter && delim_count != '1) begin
          delim_count_next = delim_count + COUNTER_WIDTH'(1);
        end
        res_emit          = 1'b1;
        res.payload_byte  = plain;
        res.frame_end     = (payload_remaining == 64'd1);
        res.bytes_total   = TOTAL_WIDTH'(payload_count_next);
        res.records_total = TOTAL_WIDTH'(delim_count_next);
        if (payload_remaining == 64'd1) begin
          frame_phase_next = PH_HDR0;
        end
      end
      default: begin
        frame_phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase       <= PH_HDR0;
      header_byte_index <= '0;
      payload_remaining <= '0;
      mask_word         <= '0;
      mask_position     <= '0;
      payload_count     <= '0;
      delim_count       <= '0;
    end else if (in_fire) begin
      frame_phase       <= frame_phase_next;
      header_byte_index <= header_byte_index_next;
      payload_remaining <= payload_remaining_next;
      mask_word         <= mask_word_next;
      mask_position     <= mask_position_next;
      payload_count     <= payload_count_next;
      delim_count       <= delim_count_next;
    end
  end

  // out register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_emit;
      end
    end else if (in_fire && res_emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire && res_emit) begin
        out_data <= res;
      end
    end else if (in_fire && res_emit) begin
      skid_data <= res;
    end
  end

  assign payload_byte  = out_data.payload_byte;
  assign frame_end     = out_data.frame_end;
  assign decode_error  = out_data.decode_error;
  assign bytes_total   = out_data.bytes_total;
  assign records_total = out_data.records_total;

  `WSU_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `WSU_ASSERT_NOW(a_error_beat_clean, out_valid && decode_error,
                  payload_byte == 8'd0 && !frame_end)
  `WSU_ASSERT_NEXT(a_halt_sticks, frame_phase == PH_HALT, frame_phase == PH_HALT)
  `WSU_ASSERT_NEXT(a_mask_pos_restart,
                   in_fire && frame_phase == PH_MASK && header_byte_index == MASK_LAST_IDX,
                   mask_position == 2'd0)
  `WSU_ASSERT_NEXT(a_frame_end_to_hdr,
                   in_fire && frame_phase == PH_PAYLOAD && payload_remaining == 64'd1,
                   frame_phase == PH_HDR0)

endmodule

### tb/websocket_frame_unmasker_checker.sv
`timescale 1ns / 100ps

module websocket_frame_unmasker_checker #(
  parameter int CW = wsu_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [7:0]                         payload_byte,
  input  logic                               frame_end,
  input  logic                               decode_error,
  input  logic [wsu_pkg::TOTAL_WIDTH-1:0]    bytes_total,
  input  logic [wsu_pkg::TOTAL_WIDTH-1:0]    records_total,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsu_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [wsu_pkg::APB_DATA_WIDTH-1:0] pwdata,
  input  logic                               pready,
  input  logic                               drain_done,
  output int                                 pending,
  output int                                 fail_count
);
  import wsu_pkg::*;

  localparam logic [CW-1:0] TOTAL_MAX = '1;

  phase_t        phase;
  logic [2:0]    hdr_idx;
  logic [63:0]   remaining;
  logic [31:0]   key;
  logic [1:0]    key_pos;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] delim_count;
  logic [7:0]    delimiter;
  logic [7:0]    plain;
  result_t       want;
  result_t       unmasked_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("%0t ns unmasker mismatch on %s: got %0h, expected %0h",
             $time, what, got, exp_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_HDR0;
      hdr_idx = '0;
      remaining = '0;
      key = '0;
      key_pos = '0;
      byte_count = '0;
      delim_count = '0;
      delimiter = DELIM_RESET;
      unmasked_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_WIDTH-1:2] == REG_RECORD_DELIMITER) begin
        delimiter = pwdata[7:0];
      end
      if (in_valid && in_ready) begin
        case (phase)
          PH_HDR0: begin
            phase = PH_HDR1;
          end
          PH_HDR1: begin
            hdr_idx = '0;
            remaining = '0;
            if ((data_byte[6:0] & LEN_FIELD_MASK) == LEN_EXT16) begin
              phase = PH_EXT16;
            end else if ((data_byte[6:0] & LEN_FIELD_MASK) == LEN_EXT64) begin
              phase = PH_EXT64;
            end else begin
              remaining = 64'(data_byte[6:0]);
              phase = PH_MASK;
            end
          end
          PH_EXT16, PH_EXT64: begin
            remaining = {remaining[55:0], data_byte};
            if ((phase == PH_EXT16 && hdr_idx == EXT16_LAST_IDX) ||
                (phase == PH_EXT64 && hdr_idx == EXT64_LAST_IDX)) begin
              hdr_idx = '0;
              phase = PH_MASK;
            end else begin
              hdr_idx = hdr_idx + 3'd1;
            end
          end
          PH_MASK: begin
            key = {key[23:0], data_byte};
            if (hdr_idx != MASK_LAST_IDX) begin
              hdr_idx = hdr_idx + 3'd1;
            end else begin
              hdr_idx = '0;
              key_pos = '0;
              if (remaining == '0) begin
                phase = PH_HALT;
                want.payload_byte = 8'h00;
                want.frame_end = 1'b0;
                want.decode_error = 1'b1;
                want.bytes_total = TOTAL_WIDTH'(byte_count);
                want.records_total = TOTAL_WIDTH'(delim_count);
                unmasked_q.push_back(want);
              end else begin
                phase = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            plain = data_byte ^ key[8 * (3 - int'(key_pos)) +: 8];
            key_pos = key_pos + 2'd1;
            remaining = remaining - 64'd1;
            if (byte_count != TOTAL_MAX) byte_count = byte_count + CW'(1);
            if (plain == delimiter && delim_count != TOTAL_MAX) begin
              delim_count = delim_count + CW'(1);
            end
            want.payload_byte = plain;
            want.frame_end = (remaining == '0);
            want.decode_error = 1'b0;
            want.bytes_total = TOTAL_WIDTH'(byte_count);
            want.records_total = TOTAL_WIDTH'(delim_count);
            if (remaining == '0) phase = PH_HDR0;
            unmasked_q.push_back(want);
          end
          PH_HALT: begin
          end
          default: begin
            phase = PH_HALT;
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (unmasked_q.size() == 0) begin
          report_mismatch("unexpected out beat", 32'(payload_byte), 32'h0);
        end else begin
          want = unmasked_q.pop_front();
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
          if (frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(frame_end), 32'(want.frame_end));
          if (decode_error !== want.decode_error)
            report_mismatch("decode_error", 32'(decode_error), 32'(want.decode_error));
          if (bytes_total !== want.bytes_total)
            report_mismatch("bytes_total", bytes_total, want.bytes_total);
          if (records_total !== want.records_total)
            report_mismatch("records_total", records_total, want.records_total);
        end
      end
      if (drain_done && unmasked_q.size() != 0) begin
        report_mismatch("beats never seen", 32'(unmasked_q.size()), 32'h0);
      end
    end
    pending = unmasked_q.size();
  end

endmodule

### tb/websocket_frame_unmasker_tb.sv
`timescale 1ns / 100ps

module websocket_frame_unmasker_tb;
  import wsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    FORM_7BIT,
    FORM_16BIT,
    FORM_64BIT
  } len_form_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                data_byte = 8'h00;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                payload_byte;
  logic                      frame_end;
  logic                      decode_error;
  logic [TOTAL_WIDTH-1:0]    bytes_total;
  logic [TOTAL_WIDTH-1:0]    records_total;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  logic                      drain_done = 1'b0;
  int                        pending;
  int                        fail_count;

  logic [7:0] delim_now = DELIM_RESET;
  bit         calm = 1'b0;
  bit         hold_off_req = 1'b0;
  bit         hold_off_done = 1'b0;
  int         idle_pct = 0;
  int         sent_bytes = 0;
  int         cycles = 0;

  websocket_frame_unmasker i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .frame_end     (frame_end),
    .decode_error  (decode_error),
    .bytes_total   (bytes_total),
    .records_total (records_total),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  websocket_frame_unmasker_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .frame_end     (frame_end),
    .decode_error  (decode_error),
    .bytes_total   (bytes_total),
    .records_total (records_total),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .drain_done    (drain_done),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (64) @(negedge clk);
        hold_off_done = 1'b1;
      end else if (calm) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
        if (!calm && $urandom_range(0, 2) != 0) begin
          out_ready = 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame(input len_form_t form, input logic [63:0] len,
                            input logic [31:0] key_in, input int delim_pct);
    logic [7:0]      b;
    longint unsigned k;
    send_byte(8'($urandom_range(0, 255)));
    case (form)
      FORM_7BIT: begin
        send_byte({1'($urandom_range(0, 1)), len[6:0]});
      end
      FORM_16BIT: begin
        send_byte({1'($urandom_range(0, 1)), LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key_in[8 * i +: 8]);
    for (k = 0; k < len; k++) begin
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < delim_pct) begin
        b = delim_now ^ key_in[8 * (3 - int'(k % 4)) +: 8];
      end
      send_byte(b);
    end
  endtask

  task automatic random_frame();
    int          r;
    logic [31:0] key_v;
    r = $urandom_range(0, 99);
    key_v = $urandom;
    if ($urandom_range(0, 15) == 0) key_v = 32'h0;
    else if ($urandom_range(0, 15) == 0) key_v = 32'hFFFF_FFFF;
    idle_pct = $urandom_range(0, 1) ? 0 : 25;
    if (r < 50) begin
      send_frame(FORM_7BIT, 64'($urandom_range(1, 12)), key_v, 15);
    end else if (r < 60) begin
      send_frame(FORM_7BIT, 64'($urandom_range(1, 125)), key_v, 15);
    end else if (r < 80) begin
      send_frame(FORM_16BIT, 64'($urandom_range(1, 40)), key_v, 15);
    end else if (r < 85) begin
      send_frame(FORM_16BIT, 64'($urandom_range(1, 300)), key_v, 15);
    end else begin
      send_frame(FORM_64BIT, 64'($urandom_range(1, 40)), key_v, 15);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [7:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_ADDR_WIDTH'(4 * REG_RECORD_DELIMITER);
    pwdata = {24'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    delim_now = v;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // short frames under the reset delimiter, non-minimal extended lengths
    idle_pct = 0;
    send_frame(FORM_7BIT, 64'd1, 32'h0000_0000, 100);
    send_frame(FORM_16BIT, 64'd2, 32'hFFFF_FFFF, 50);
    send_frame(FORM_64BIT, 64'd1, 32'h80FF_017F, 0);
    settle();
    apb_write(8'h00);

    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        settle();
        if (p == 1) apb_write(8'hFF);
        else if (p == 2) apb_write(8'($urandom_range(0, 255)));
        else apb_write(DELIM_RESET);
      end
      if (p == 3) calm = 1'b1;
      if (p == 1) begin
        // long receiver stall while a long frame keeps coming
        idle_pct = 0;
        hold_off_req = 1'b1;
        send_frame(FORM_7BIT, 64'd120, $urandom, 10);
      end
      while (sent_bytes < (p + 1) * 400 + 32) random_frame();
    end

    // zero-length frame halts decoding; later beats are dropped
    send_frame(len_form_t'($urandom_range(0, 2)), 64'd0, $urandom, 0);
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    drain_done = 1'b1;
    @(negedge clk);
    drain_done = 1'b0;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/wsu_pkg.sv
design/websocket_frame_unmasker.sv
tb/websocket_frame_unmasker_checker.sv
tb/websocket_frame_unmasker_tb.sv
